// ===== rtl/brb_pkg.sv =====
// Shared types and constants for the burst byte ring buffer.
// Used by brb_seq, byte_ring_buffer_burst and brb_chk; depends on nothing.

package brb_pkg;

  localparam int unsigned STORE_BYTES_DEF = 4096;
  localparam int unsigned BURST_BYTES_DEF = 4;

  localparam int unsigned CFG_W  = 13;
  localparam int unsigned LEN_W  = 3;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned USED_W = 13;
  localparam int unsigned LANES  = DATA_W / 8;

  localparam logic [CFG_W-1:0] CAP_RESET = 13'd4096;

  localparam logic OP_PUT = 1'b0;
  localparam logic OP_GET = 1'b1;

  typedef struct packed {
    logic              opcode;
    logic [LEN_W-1:0]  length;
    logic [DATA_W-1:0] write_data;
  } brb_in_t;

  typedef struct packed {
    logic              accepted;
    logic [DATA_W-1:0] read_data;
    logic [USED_W-1:0] used_bytes;
  } brb_out_t;

endpackage

// ===== rtl/brb_mem.sv =====
// Byte-wide synchronous RAM of the ring buffer, one write and one read port.
// Read data is registered. Depends on nothing.

module brb_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned AW    = 12
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [7:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/brb_seq.sv =====
// Burst sequencer: admission check, byte-serial store access, index and fill
// bookkeeping, and the result register. Depends on brb_pkg.

module brb_seq #(
  parameter int unsigned STORE_BYTES = brb_pkg::STORE_BYTES_DEF,
  parameter int unsigned BURST_BYTES = brb_pkg::BURST_BYTES_DEF,
  parameter int unsigned PTR_W       = $clog2(STORE_BYTES),
  parameter int unsigned CNT_W       = $clog2(STORE_BYTES + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic [CNT_W-1:0]  cap_i,
  input  logic              start_i,
  input  brb_pkg::brb_in_t  item_i,
  output logic              busy_o,
  output logic              res_valid_o,
  output brb_pkg::brb_out_t res_o,
  output logic              mem_we_o,
  output logic [PTR_W-1:0]  mem_waddr_o,
  output logic [7:0]        mem_wdata_o,
  output logic              mem_re_o,
  output logic [PTR_W-1:0]  mem_raddr_o,
  input  logic [7:0]        mem_rdata_i
);

  typedef enum logic [1:0] {S_IDLE, S_XFER, S_LAST} state_e;

  state_e                      state_q;
  logic                        op_q;
  logic [brb_pkg::LEN_W-1:0]   len_q;
  logic [brb_pkg::LEN_W-1:0]   cnt_q;
  logic [brb_pkg::DATA_W-1:0]  wdata_q;
  logic [brb_pkg::DATA_W-1:0]  rdata_q;
  logic                        ok_q;
  logic                        pend_q;
  logic [brb_pkg::LEN_W-1:0]   plane_q;
  logic [PTR_W-1:0]            widx_q;
  logic [PTR_W-1:0]            ridx_q;
  logic [CNT_W-1:0]            fill_q;
  logic                        res_valid_q;
  brb_pkg::brb_out_t           res_q;

  logic [CNT_W-1:0]            winc;
  logic [CNT_W-1:0]            rinc;
  logic [PTR_W-1:0]            widx_nx;
  logic [PTR_W-1:0]            ridx_nx;
  logic [CNT_W-1:0]            free_bytes;
  logic                        ok;
  logic [CNT_W-1:0]            fill_nx;
  logic [7:0]                  put_byte;
  logic [brb_pkg::DATA_W-1:0]  rdata_m;

  // Indices step by one and wrap to zero at the capacity.
  assign winc    = CNT_W'(widx_q) + CNT_W'(1);
  assign rinc    = CNT_W'(ridx_q) + CNT_W'(1);
  assign widx_nx = (winc >= cap_i) ? '0 : PTR_W'(winc);
  assign ridx_nx = (rinc >= cap_i) ? '0 : PTR_W'(rinc);

  assign free_bytes = cap_i - fill_q;

  always_comb begin
    ok = 1'b0;
    if (32'(item_i.length) <= 32'(BURST_BYTES)) begin
      if (item_i.opcode == brb_pkg::OP_GET) begin
        ok = 32'(item_i.length) <= 32'(fill_q);
      end else begin
        ok = 32'(item_i.length) <= 32'(free_bytes);
      end
    end
  end

  always_comb begin
    if (!ok_q) begin
      fill_nx = fill_q;
    end else if (op_q == brb_pkg::OP_GET) begin
      fill_nx = CNT_W'(32'(fill_q) - 32'(len_q));
    end else begin
      fill_nx = CNT_W'(32'(fill_q) + 32'(len_q));
    end
  end

  // Bytes beyond the carried lanes are stored as zero.
  always_comb begin
    put_byte = '0;
    for (int i = 0; i < brb_pkg::LANES; i++) begin
      if (cnt_q == brb_pkg::LEN_W'(i)) begin
        put_byte = wdata_q[8*i +: 8];
      end
    end
  end

  // Merge the byte returned by last cycle's read into its lane.
  always_comb begin
    rdata_m = rdata_q;
    if (pend_q) begin
      for (int i = 0; i < brb_pkg::LANES; i++) begin
        if (plane_q == brb_pkg::LEN_W'(i)) begin
          rdata_m[8*i +: 8] = mem_rdata_i;
        end
      end
    end
  end

  assign mem_we_o    = (state_q == S_XFER) && (op_q == brb_pkg::OP_PUT);
  assign mem_waddr_o = widx_q;
  assign mem_wdata_o = put_byte;
  assign mem_re_o    = (state_q == S_XFER) && (op_q == brb_pkg::OP_GET);
  assign mem_raddr_o = ridx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      widx_q      <= '0;
      ridx_q      <= '0;
      fill_q      <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
      ok_q        <= 1'b0;
      cnt_q       <= '0;
    end else begin
      res_valid_q <= 1'b0;
      pend_q      <= mem_re_o;
      plane_q     <= cnt_q;
      rdata_q     <= rdata_m;
      if (clr_i) begin
        widx_q <= '0;
        ridx_q <= '0;
        fill_q <= '0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            op_q    <= item_i.opcode;
            len_q   <= item_i.length;
            wdata_q <= item_i.write_data;
            cnt_q   <= '0;
            ok_q    <= ok;
            rdata_q <= '0;
            state_q <= (ok && item_i.length != '0) ? S_XFER : S_LAST;
          end
        end
        S_XFER: begin
          if (op_q == brb_pkg::OP_GET) begin
            ridx_q <= ridx_nx;
          end else begin
            widx_q <= widx_nx;
          end
          cnt_q <= cnt_q + brb_pkg::LEN_W'(1);
          if (cnt_q == len_q - brb_pkg::LEN_W'(1)) begin
            state_q <= S_LAST;
          end
        end
        S_LAST: begin
          fill_q           <= fill_nx;
          res_valid_q      <= 1'b1;
          res_q.accepted   <= ok_q;
          res_q.read_data  <= rdata_m;
          res_q.used_bytes <= brb_pkg::USED_W'(fill_nx);
          state_q          <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// ===== rtl/byte_ring_buffer_burst.sv =====
// Top level of the burst byte ring buffer: capacity register, sequencer and
// byte store. Depends on brb_pkg, brb_seq and brb_mem.

// A word is one burst: a put or a get of 0 to BURST_BYTES bytes, done whole or
// refused whole. A word is taken on a clock edge where start is high and busy
// is low, and busy stays high until its result has been produced. A word that
// is admitted is checked when it is taken, then moved one byte per cycle
// through the byte store, which has one byte-wide write port and one
// byte-wide read port, and then written to the result register; a refused or
// empty word goes from the admission check straight to the result register.
// The result is shown for exactly one cycle with result_valid_o high; the
// receiver cannot stall it, so it must take it then.
// A new word may be started in the same cycle the previous result is shown.
// Writing the capacity register empties the queue; write it only while the
// block is idle. The store has no reset: only bytes that were put are read.

module byte_ring_buffer_burst #(
  parameter int unsigned STORE_BYTES = brb_pkg::STORE_BYTES_DEF,
  parameter int unsigned BURST_BYTES = brb_pkg::BURST_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [brb_pkg::CFG_W-1:0]   cfg_wdata_i,
  input  logic                        start,
  input  brb_pkg::brb_in_t            item_i,
  output logic                        busy,
  output logic                        result_valid_o,
  output brb_pkg::brb_out_t           result_o
);

  localparam int unsigned PTR_W = $clog2(STORE_BYTES);
  localparam int unsigned CNT_W = $clog2(STORE_BYTES + 1);

  logic [brb_pkg::CFG_W-1:0] cap_q;
  logic [CNT_W-1:0]          cap_eff;

  logic             mem_we;
  logic [PTR_W-1:0] mem_waddr;
  logic [7:0]       mem_wdata;
  logic             mem_re;
  logic [PTR_W-1:0] mem_raddr;
  logic [7:0]       mem_rdata;

  // The capacity register holds the raw value written.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= brb_pkg::CAP_RESET;
    end else if (cfg_we_i) begin
      cap_q <= cfg_wdata_i;
    end
  end

  // A capacity of zero acts as one; anything above the store size is clamped.
  always_comb begin
    if (cap_q == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(cap_q) > 32'(STORE_BYTES)) begin
      cap_eff = CNT_W'(STORE_BYTES);
    end else begin
      cap_eff = CNT_W'(cap_q);
    end
  end

  brb_seq #(
    .STORE_BYTES (STORE_BYTES),
    .BURST_BYTES (BURST_BYTES),
    .PTR_W       (PTR_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (cfg_we_i),
    .cap_i       (cap_eff),
    .start_i     (start),
    .item_i      (item_i),
    .busy_o      (busy),
    .res_valid_o (result_valid_o),
    .res_o       (result_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  brb_mem #(
    .DEPTH (STORE_BYTES),
    .AW    (PTR_W)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule

// ===== rtl/brb_chk.sv =====
// Port-level checker for the burst byte ring buffer and its bind statement.
// Depends on brb_pkg and byte_ring_buffer_burst.

module brb_chk (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input logic              result_valid_o,
  input brb_pkg::brb_out_t result_o
);

  // A taken word keeps the block busy in the following cycle.
  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after a word was taken");

  // A result only appears once the block has finished its word.
  a_result_when_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> !busy)
    else $error("result shown while busy");

  // One word gives one result, never two in a row.
  a_single_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe longer than one cycle");

  // A refused word returns no data.
  a_refused_no_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !result_o.accepted |-> result_o.read_data == '0)
    else $error("refused word returned data");

endmodule

bind byte_ring_buffer_burst brb_chk u_brb_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .result_o       (result_o)
);
